### sv/mrbg_pkg.sv
// Shared types and constants for the multi-ring basin grouper.
// Used by multiring_basin_grouper; depends on nothing else.
package mrbg_pkg;

    // Store sizing and field widths.
    localparam int MAX_CAND = 64;
    localparam int IDX_W    = $clog2(MAX_CAND);
    localparam int CNT_W    = IDX_W + 1;
    localparam int RAD_W    = 24;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 16;
    localparam int BID_W    = 6;
    localparam int RING_W   = 7;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0] TOL_RESET   = 16'd1024;
    localparam logic [CFG_W-1:0] RATIO_RESET = 16'd5120;

    // Register indexes, taken from paddr[2].
    typedef enum logic {
        t_REG_TOL   = 1'b0,
        t_REG_RATIO = 1'b1
    } t_reg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_SEED_RD,
        S_SEED_CHK,
        S_CAND_RD,
        S_CAND_CHK,
        S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9,
        S_RM_RD, S_RM_RD2, S_RM_MUL, S_RM_CHK,
        S_SA_RD, S_SA_RD2, S_SA_GET,
        S_SB_RD, S_SB_RD2, S_SB_CMP, S_SA_WB,
        S_T_RD, S_T_WR,
        S_O_RD, S_O_EMIT
    } t_state;

endpackage

### sv/multiring_basin_grouper.sv
// Multi-ring basin grouper: loads circles, groups concentric rings, emits tags.
// Depends on mrbg_pkg for sizes, register indexes and sequencer states.
//
// A non-final item is stored while busy stays low. The final item starts
// grouping, during which busy is high: the tags are cleared first, then each
// untagged seed walks all stored circles as candidates, each eligible one
// going through the one shared 32x32 multiplier and, if close enough, a ratio
// test against each ring already gathered; a basin of c rings is then sorted
// by radius and tagged. Results then leave one at a time, each marked by
// o_valid for one cycle; the receiver cannot stall them and must take each
// transaction as it appears.
module multiring_basin_grouper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           i_centre_x,
    input  logic signed [31:0]           i_centre_y,
    input  logic [23:0]                  i_radius,
    input  logic                         i_final_item,
    output logic                         o_valid,
    output logic [5:0]                   o_basin_num,
    output logic [6:0]                   o_ring_pos,
    output logic [5:0]                   o_basin_count,
    output logic                         o_end_of_set,
    output logic                         o_overflow,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IW = mrbg_pkg::IDX_W;
    localparam int CW = mrbg_pkg::CNT_W;
    localparam int RW = mrbg_pkg::RAD_W;
    localparam int PW = mrbg_pkg::POS_W;

    // Memories.
    logic signed [PW-1:0]             mem_x  [mrbg_pkg::MAX_CAND];
    logic signed [PW-1:0]             mem_y  [mrbg_pkg::MAX_CAND];
    logic [RW-1:0]                    mem_r  [mrbg_pkg::MAX_CAND];
    logic [mrbg_pkg::BID_W-1:0]       mem_bt [mrbg_pkg::MAX_CAND];
    logic [mrbg_pkg::RING_W-1:0]      mem_rt [mrbg_pkg::MAX_CAND];
    logic [IW-1:0]                    mem_ml [mrbg_pkg::MAX_CAND];

    // Registered read data.
    logic signed [PW-1:0]             r_x_q, r_y_q;
    logic [RW-1:0]                    r_ra_q, r_rb_q;
    logic [mrbg_pkg::BID_W-1:0]       r_bt_q;
    logic [mrbg_pkg::RING_W-1:0]      r_rt_q;
    logic [IW-1:0]                    r_ml_q;

    // Control and datapath registers.
    mrbg_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_lc, n_lc;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_m, n_m;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [mrbg_pkg::BID_W-1:0] r_nb, n_nb;
    logic [mrbg_pkg::CFG_W-1:0] r_tol, r_ratio;

    logic signed [PW-1:0] r_xi, n_xi, r_yi, n_yi;
    logic [RW-1:0] r_ri, n_ri, r_rj, n_rj, r_rmin, n_rmin, r_rh, n_rh, r_ar, n_ar;
    logic [PW-1:0] r_dx, n_dx, r_dy, n_dy;
    logic [64:0]   r_acc, n_acc;
    logic [39:0]   r_lim, n_lim;
    logic [79:0]   r_l2, n_l2;
    logic [IW-1:0] r_ai, n_ai, r_bi, n_bi;
    logic [63:0]   r_prod;

    // Combinational controls.
    logic [31:0]   mul_a, mul_b;
    logic [IW-1:0] addr_a, ml_raddr;
    logic          tag_we, ml_we;
    logic [IW-1:0] tag_waddr, ml_waddr, ml_wdata;
    logic [mrbg_pkg::BID_W-1:0]  bt_wdata;
    logic [mrbg_pkg::RING_W-1:0] rt_wdata;
    logic          load_we;

    logic [PW:0]   diff_x, diff_y;
    logic [88:0]   d2_shift;
    logic [RW-1:0] rl_c, rh_c;
    logic [35:0]   rh_sh;

    // APB port: writes complete in the access cycle, reads return the register.
    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == mrbg_pkg::t_REG_RATIO) begin
            prdata = {16'd0, r_ratio};
        end else begin
            prdata = {16'd0, r_tol};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= mrbg_pkg::TOL_RESET;
            r_ratio <= mrbg_pkg::RATIO_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == mrbg_pkg::t_REG_RATIO) begin
                r_ratio <= pwdata[15:0];
            end else begin
                r_tol <= pwdata[15:0];
            end
        end
    end

    assign busy    = (r_state != mrbg_pkg::S_IDLE);
    assign load_we = (r_state == mrbg_pkg::S_IDLE) && start && (r_lc < CW'(mrbg_pkg::MAX_CAND));

    // Output transaction, shown for one cycle.
    assign o_valid       = (r_state == mrbg_pkg::S_O_EMIT);
    assign o_basin_num   = r_bt_q;
    assign o_ring_pos    = r_rt_q;
    assign o_basin_count = r_nb - 6'd1;
    assign o_end_of_set  = (r_k + CW'(1) == r_n);
    assign o_overflow    = r_ovf;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_x[r_lc[IW-1:0]] <= i_centre_x;
            mem_y[r_lc[IW-1:0]] <= i_centre_y;
            mem_r[r_lc[IW-1:0]] <= i_radius;
        end
        if (tag_we) begin
            mem_bt[tag_waddr] <= bt_wdata;
            mem_rt[tag_waddr] <= rt_wdata;
        end
        if (ml_we) begin
            mem_ml[ml_waddr] <= ml_wdata;
        end
        r_x_q  <= mem_x[addr_a];
        r_y_q  <= mem_y[addr_a];
        r_ra_q <= mem_r[addr_a];
        r_bt_q <= mem_bt[addr_a];
        r_rt_q <= mem_rt[addr_a];
        r_ml_q <= mem_ml[ml_raddr];
        r_rb_q <= mem_r[r_ml_q];
    end

    // Shared multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Sequencer state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrbg_pkg::S_IDLE;
            r_lc    <= '0;
            r_ovf   <= 1'b0;
            r_nb    <= 6'd1;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_ovf   <= n_ovf;
            r_nb    <= n_nb;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_a     <= n_a;
            r_b     <= n_b;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_xi   <= n_xi;
        r_yi   <= n_yi;
        r_ri   <= n_ri;
        r_rj   <= n_rj;
        r_rmin <= n_rmin;
        r_rh   <= n_rh;
        r_ar   <= n_ar;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_acc  <= n_acc;
        r_lim  <= n_lim;
        r_l2   <= n_l2;
        r_ai   <= n_ai;
        r_bi   <= n_bi;
    end

    // Helper arithmetic for the candidate and ratio tests.
    assign diff_x   = {r_xi[PW-1], r_xi} - {r_x_q[PW-1], r_x_q};
    assign diff_y   = {r_yi[PW-1], r_yi} - {r_y_q[PW-1], r_y_q};
    assign d2_shift = {r_acc, 24'd0};
    assign rl_c     = (r_rb_q < r_rj) ? r_rb_q : r_rj;
    assign rh_c     = (r_rb_q < r_rj) ? r_rj : r_rb_q;
    assign rh_sh    = {r_rh, 12'd0};

    // Next state, datapath updates and memory controls.
    always_comb begin
        n_state = r_state;
        n_lc = r_lc;   n_ovf = r_ovf; n_nb = r_nb;  n_n = r_n;
        n_i = r_i;     n_j = r_j;     n_m = r_m;    n_a = r_a;
        n_b = r_b;     n_k = r_k;     n_cnt = r_cnt;
        n_xi = r_xi;   n_yi = r_yi;   n_ri = r_ri;  n_rj = r_rj;
        n_rmin = r_rmin; n_rh = r_rh; n_ar = r_ar;
        n_dx = r_dx;   n_dy = r_dy;   n_acc = r_acc; n_lim = r_lim;
        n_l2 = r_l2;   n_ai = r_ai;   n_bi = r_bi;
        mul_a = '0;    mul_b = '0;
        addr_a = '0;   ml_raddr = '0;
        tag_we = 1'b0; tag_waddr = '0; bt_wdata = '0; rt_wdata = '0;
        ml_we = 1'b0;  ml_waddr = '0;  ml_wdata = '0;

        case (r_state)
            // Load circles; the final one starts grouping.
            mrbg_pkg::S_IDLE: begin
                if (start) begin
                    if (r_lc < CW'(mrbg_pkg::MAX_CAND)) begin
                        n_lc = r_lc + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_item) begin
                        n_n     = (r_lc < CW'(mrbg_pkg::MAX_CAND)) ? r_lc + CW'(1) : r_lc;
                        n_k     = '0;
                        n_nb    = 6'd1;
                        n_state = mrbg_pkg::S_CLR;
                    end
                end
            end

            // Clear the tags of the stored circles.
            mrbg_pkg::S_CLR: begin
                tag_we    = 1'b1;
                tag_waddr = r_k[IW-1:0];
                n_k       = r_k + CW'(1);
                if (r_k + CW'(1) >= r_n) begin
                    n_k = '0;
                    n_i = '0;
                    n_state = (r_n < CW'(2)) ? mrbg_pkg::S_O_RD : mrbg_pkg::S_SEED_RD;
                end
            end

            // Pick the next seed if it is not yet in a basin.
            mrbg_pkg::S_SEED_RD: begin
                addr_a  = r_i[IW-1:0];
                n_state = mrbg_pkg::S_SEED_CHK;
            end

            mrbg_pkg::S_SEED_CHK: begin
                if (r_bt_q != '0) begin
                    n_i = r_i + CW'(1);
                    n_state = (r_i + CW'(1) == r_n) ? mrbg_pkg::S_O_RD : mrbg_pkg::S_SEED_RD;
                end else begin
                    n_xi     = r_x_q;
                    n_yi     = r_y_q;
                    n_ri     = r_ra_q;
                    ml_we    = 1'b1;
                    ml_waddr = '0;
                    ml_wdata = r_i[IW-1:0];
                    n_cnt    = CW'(1);
                    n_j      = '0;
                    n_state  = mrbg_pkg::S_CAND_RD;
                end
            end

            // Fetch a candidate.
            mrbg_pkg::S_CAND_RD: begin
                addr_a  = r_j[IW-1:0];
                n_state = mrbg_pkg::S_CAND_CHK;
            end

            mrbg_pkg::S_CAND_CHK: begin
                if ((r_j == r_i) || (r_bt_q != '0)) begin
                    n_j = r_j + CW'(1);
                    n_state = (r_j + CW'(1) == r_n) ? mrbg_pkg::S_SA_RD : mrbg_pkg::S_CAND_RD;
                end else begin
                    n_dx    = diff_x[PW] ? PW'(-diff_x) : diff_x[PW-1:0];
                    n_dy    = diff_y[PW] ? PW'(-diff_y) : diff_y[PW-1:0];
                    n_rj    = r_ra_q;
                    n_rmin  = (r_ra_q < r_ri) ? r_ra_q : r_ri;
                    n_state = mrbg_pkg::S_D1;
                end
            end

            // Squared distance and squared limit through the multiplier.
            mrbg_pkg::S_D1: begin
                mul_a = r_dx; mul_b = r_dx;
                n_state = mrbg_pkg::S_D2;
            end
            mrbg_pkg::S_D2: begin
                mul_a = r_dy; mul_b = r_dy;
                n_acc = {1'b0, r_prod};
                n_state = mrbg_pkg::S_D3;
            end
            mrbg_pkg::S_D3: begin
                mul_a = {16'd0, r_tol}; mul_b = {8'd0, r_rmin};
                n_acc = r_acc + {1'b0, r_prod};
                n_state = mrbg_pkg::S_D4;
            end
            mrbg_pkg::S_D4: begin
                n_lim = r_prod[39:0];
                n_state = mrbg_pkg::S_D5;
            end
            mrbg_pkg::S_D5: begin
                mul_a = r_lim[31:0]; mul_b = r_lim[31:0];
                n_state = mrbg_pkg::S_D6;
            end
            mrbg_pkg::S_D6: begin
                mul_a = r_lim[31:0]; mul_b = {24'd0, r_lim[39:32]};
                n_l2 = {16'd0, r_prod};
                n_state = mrbg_pkg::S_D7;
            end
            mrbg_pkg::S_D7: begin
                mul_a = {24'd0, r_lim[39:32]}; mul_b = {24'd0, r_lim[39:32]};
                n_l2 = r_l2 + {r_prod[46:0], 33'd0};
                n_state = mrbg_pkg::S_D8;
            end
            mrbg_pkg::S_D8: begin
                n_l2 = r_l2 + {r_prod[15:0], 64'd0};
                n_state = mrbg_pkg::S_D9;
            end
            mrbg_pkg::S_D9: begin
                if (d2_shift > {9'd0, r_l2}) begin
                    n_j = r_j + CW'(1);
                    n_state = (r_j + CW'(1) == r_n) ? mrbg_pkg::S_SA_RD : mrbg_pkg::S_CAND_RD;
                end else begin
                    n_m = '0;
                    n_state = mrbg_pkg::S_RM_RD;
                end
            end

            // Ratio test against each gathered ring.
            mrbg_pkg::S_RM_RD: begin
                ml_raddr = r_m[IW-1:0];
                n_state  = mrbg_pkg::S_RM_RD2;
            end
            mrbg_pkg::S_RM_RD2: begin
                n_state = mrbg_pkg::S_RM_MUL;
            end
            mrbg_pkg::S_RM_MUL: begin
                mul_a = {16'd0, r_ratio}; mul_b = {8'd0, rl_c};
                n_rh  = rh_c;
                if (rl_c == '0) begin
                    n_j = r_j + CW'(1);
                    n_state = (r_j + CW'(1) == r_n) ? mrbg_pkg::S_SA_RD : mrbg_pkg::S_CAND_RD;
                end else begin
                    n_state = mrbg_pkg::S_RM_CHK;
                end
            end
            mrbg_pkg::S_RM_CHK: begin
                if ({4'd0, rh_sh} >= r_prod[39:0]) begin
                    n_m = r_m + CW'(1);
                    if (r_m + CW'(1) == r_cnt) begin
                        if (r_cnt < CW'(mrbg_pkg::MAX_CAND)) begin
                            ml_we    = 1'b1;
                            ml_waddr = r_cnt[IW-1:0];
                            ml_wdata = r_j[IW-1:0];
                            n_cnt    = r_cnt + CW'(1);
                        end
                        n_j = r_j + CW'(1);
                        n_state = (r_j + CW'(1) == r_n) ? mrbg_pkg::S_SA_RD
                                                        : mrbg_pkg::S_CAND_RD;
                    end else begin
                        n_state = mrbg_pkg::S_RM_RD;
                    end
                end else begin
                    n_j = r_j + CW'(1);
                    n_state = (r_j + CW'(1) == r_n) ? mrbg_pkg::S_SA_RD : mrbg_pkg::S_CAND_RD;
                end
            end

            // Exchange sort by radius; the running minimum is held in registers.
            mrbg_pkg::S_SA_RD: begin
                if (r_cnt < CW'(2)) begin
                    n_i = r_i + CW'(1);
                    n_state = (r_i + CW'(1) == r_n) ? mrbg_pkg::S_O_RD : mrbg_pkg::S_SEED_RD;
                end else begin
                    ml_raddr = r_a[IW-1:0];
                    n_state  = mrbg_pkg::S_SA_RD2;
                end
            end
            mrbg_pkg::S_SA_RD2: begin
                n_ai    = r_ml_q;
                n_state = mrbg_pkg::S_SA_GET;
            end
            mrbg_pkg::S_SA_GET: begin
                n_ar    = r_rb_q;
                n_b     = r_a + CW'(1);
                n_state = mrbg_pkg::S_SB_RD;
            end
            mrbg_pkg::S_SB_RD: begin
                ml_raddr = r_b[IW-1:0];
                n_state  = mrbg_pkg::S_SB_RD2;
            end
            mrbg_pkg::S_SB_RD2: begin
                n_bi    = r_ml_q;
                n_state = mrbg_pkg::S_SB_CMP;
            end
            mrbg_pkg::S_SB_CMP: begin
                if (r_ar > r_rb_q) begin
                    ml_we    = 1'b1;
                    ml_waddr = r_b[IW-1:0];
                    ml_wdata = r_ai;
                    n_ai     = r_bi;
                    n_ar     = r_rb_q;
                end
                n_b = r_b + CW'(1);
                n_state = (r_b + CW'(1) == r_cnt) ? mrbg_pkg::S_SA_WB : mrbg_pkg::S_SB_RD;
            end
            mrbg_pkg::S_SA_WB: begin
                ml_we    = 1'b1;
                ml_waddr = r_a[IW-1:0];
                ml_wdata = r_ai;
                n_a      = r_a + CW'(1);
                if (r_a + CW'(2) >= r_cnt) begin
                    n_a = '0;
                    n_state = mrbg_pkg::S_T_RD;
                end else begin
                    n_state = mrbg_pkg::S_SA_RD;
                end
            end

            // Tag the rings of the new basin.
            mrbg_pkg::S_T_RD: begin
                ml_raddr = r_a[IW-1:0];
                n_state  = mrbg_pkg::S_T_WR;
            end
            mrbg_pkg::S_T_WR: begin
                tag_we    = 1'b1;
                tag_waddr = r_ml_q;
                bt_wdata  = r_nb;
                rt_wdata  = r_a + CW'(1);
                n_a       = r_a + CW'(1);
                if (r_a + CW'(1) == r_cnt) begin
                    n_a  = '0;
                    n_nb = r_nb + 6'd1;
                    n_i  = r_i + CW'(1);
                    n_state = (r_i + CW'(1) == r_n) ? mrbg_pkg::S_O_RD : mrbg_pkg::S_SEED_RD;
                end else begin
                    n_state = mrbg_pkg::S_T_RD;
                end
            end

            // Emit one result per stored circle in load order.
            mrbg_pkg::S_O_RD: begin
                addr_a  = r_k[IW-1:0];
                n_state = mrbg_pkg::S_O_EMIT;
            end
            mrbg_pkg::S_O_EMIT: begin
                n_k = r_k + CW'(1);
                if (r_k + CW'(1) >= r_n) begin
                    n_k     = '0;
                    n_lc    = '0;
                    n_ovf   = 1'b0;
                    n_nb    = 6'd1;
                    n_state = mrbg_pkg::S_IDLE;
                end else begin
                    n_state = mrbg_pkg::S_O_RD;
                end
            end

            default: begin
                n_state = mrbg_pkg::S_IDLE;
            end
        endcase
    end

endmodule
